// ===== rtl/edmt_pkg.sv =====
package edmt_pkg;

  // Field widths of the transaction ports.
  localparam int EGGS_W   = 10;
  localparam int FLOORS_W = 10;
  localparam int TRIALS_W = 10;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_ROW0,
    ST_ROW1,
    ST_CELL,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_CELL_WR,
    ST_ROW_END,
    ST_RES_RD,
    ST_RES_LD,
    ST_DONE
  } state_t;

  // Source of the row write data.
  typedef enum logic [2:0] {
    WD_J,
    WD_ZERO,
    WD_ONE,
    WD_PREV,
    WD_BEST1
  } wd_sel_t;

  // Address of the previous-row read.
  typedef enum logic [1:0] {
    PA_XM1,
    PA_J,
    PA_K
  } pa_sel_t;

  // Source of the result register.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_K,
    RES_MEM
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     j_clr;
    logic     j_inc;
    logic     i_set2;
    logic     i_inc;
    logic     x_set1;
    logic     x_inc;
    logic     best_clr;
    logic     scan_rd;
    pa_sel_t  pa_sel;
    logic     wr_en;
    logic     wr_prev;
    wd_sel_t  wd_sel;
    logic     swap;
    logic     res_ld;
    res_sel_t res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_zero;
    logic k_one;
    logic n_zero;
    logic n_one;
    logic j_eq_k;
    logic x_eq_j;
    logic i_gt_j;
    logic i_eq_n;
  } stat_t;

endpackage

// ===== rtl/edmt_ram.sv =====
module edmt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/edmt_ctrl.sv =====
module edmt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  edmt_pkg::stat_t stat,
  output edmt_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);

  import edmt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.k_zero || stat.k_one || stat.n_zero || stat.n_one) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (stat.j_eq_k) state_nxt = ST_ROW0;
      end
      ST_ROW0:    state_nxt = ST_ROW1;
      ST_ROW1:    state_nxt = ST_CELL;
      ST_CELL: begin
        state_nxt = stat.i_gt_j ? ST_COPY_RD : ST_SCAN;
      end
      ST_COPY_RD: state_nxt = ST_COPY_WR;
      ST_SCAN: begin
        if (stat.x_eq_j) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:   state_nxt = ST_CELL_WR;
      ST_COPY_WR, ST_CELL_WR: begin
        state_nxt = stat.j_eq_k ? ST_ROW_END : ST_CELL;
      end
      ST_ROW_END: begin
        state_nxt = stat.i_eq_n ? ST_RES_RD : ST_ROW0;
      end
      ST_RES_RD:  state_nxt = ST_RES_LD;
      ST_RES_LD:  state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.pa_sel   = PA_XM1;
    cmd.wd_sel   = WD_J;
    cmd.res_sel  = RES_ZERO;
    busy         = (state_r != ST_IDLE);
    out_valid    = (state_r == ST_DONE);
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.res_ld = 1'b1;
        if (stat.k_zero) begin
          cmd.res_sel = RES_ZERO;
        end else if (stat.k_one) begin
          cmd.res_sel = RES_ONE;
        end else if (stat.n_zero) begin
          cmd.res_sel = RES_ZERO;
        end else begin
          cmd.res_sel = RES_K;
        end
      end
      ST_INIT: begin
        // One-egg row: each entry holds its own floor count.
        cmd.wr_en   = 1'b1;
        cmd.wr_prev = 1'b1;
        cmd.wd_sel  = WD_J;
        if (stat.j_eq_k) begin
          cmd.j_clr  = 1'b1;
          cmd.i_set2 = 1'b1;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      ST_ROW0: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_ZERO;
        cmd.j_inc  = 1'b1;
      end
      ST_ROW1: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_ONE;
        cmd.j_inc  = 1'b1;
      end
      ST_CELL: begin
        cmd.x_set1   = 1'b1;
        cmd.best_clr = 1'b1;
        cmd.pa_sel   = PA_J;
      end
      ST_COPY_RD: begin
        cmd.pa_sel = PA_J;
      end
      ST_SCAN: begin
        cmd.pa_sel  = PA_XM1;
        cmd.scan_rd = 1'b1;
        cmd.x_inc   = 1'b1;
      end
      ST_COPY_WR, ST_CELL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = (state_r == ST_COPY_WR) ? WD_PREV : WD_BEST1;
        cmd.j_inc  = !stat.j_eq_k;
      end
      ST_ROW_END: begin
        cmd.swap  = 1'b1;
        cmd.j_clr = 1'b1;
        cmd.i_inc = !stat.i_eq_n;
      end
      ST_RES_RD: begin
        cmd.pa_sel = PA_K;
      end
      ST_RES_LD: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_MEM;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/edmt_dp.sv =====
module edmt_dp #(
  parameter int MAX_FLOORS = 1023,
  parameter int MAX_EGGS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [edmt_pkg::EGGS_W-1:0]     in_eggs,
  input  logic [edmt_pkg::FLOORS_W-1:0]   in_floors,
  input  edmt_pkg::cmd_t                  cmd,
  output edmt_pkg::stat_t                 stat,
  output logic [edmt_pkg::TRIALS_W-1:0]   out_trials
);

  import edmt_pkg::*;

  localparam int FW   = $clog2(MAX_FLOORS + 1);
  localparam int EW   = $clog2(MAX_EGGS + 1);
  localparam int CMPW = (FW > EW) ? FW : EW;

  logic [EW-1:0]       n_r, i_r;
  logic [FW-1:0]       k_r, j_r, x_r;
  logic [TRIALS_W-1:0] best_r, res_r;
  logic                sel_r, rd_pend_r;

  logic [FW-1:0]       prev_addr, cur_addr;
  logic [TRIALS_W-1:0] a_rd, b_rd, prev_rd, cur_rd, worst, wdata;
  logic [FW-1:0]       a_raddr, b_raddr;
  logic                a_we, b_we;
  logic                eggs_sat, floors_sat;

  // Saturate the transaction fields at the table limits.
  assign eggs_sat   = (32'(in_eggs) > 32'(MAX_EGGS));
  assign floors_sat = (32'(in_floors) > 32'(MAX_FLOORS));

  // Problem size and loop counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= eggs_sat ? EW'(MAX_EGGS) : EW'(in_eggs);
      k_r <= floors_sat ? FW'(MAX_FLOORS) : FW'(in_floors);
    end
    if (cmd.i_set2) begin
      i_r <= EW'(2);
    end else if (cmd.i_inc) begin
      i_r <= i_r + EW'(1);
    end
    if (cmd.load || cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + FW'(1);
    end
    if (cmd.x_set1) begin
      x_r <= FW'(1);
    end else if (cmd.x_inc) begin
      x_r <= x_r + FW'(1);
    end
  end

  // Row select flips at each row end so the two RAMs trade roles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
      if (cmd.load) begin
        sel_r <= 1'b0;
      end else if (cmd.swap) begin
        sel_r <= !sel_r;
      end
    end
  end

  // Read addresses for the two rows.
  always_comb begin
    case (cmd.pa_sel)
      PA_XM1:  prev_addr = x_r - FW'(1);
      PA_J:    prev_addr = j_r;
      PA_K:    prev_addr = k_r;
      default: prev_addr = j_r;
    endcase
  end
  assign cur_addr = j_r - x_r;

  assign a_raddr = sel_r ? cur_addr : prev_addr;
  assign b_raddr = sel_r ? prev_addr : cur_addr;
  assign prev_rd = sel_r ? b_rd : a_rd;
  assign cur_rd  = sel_r ? a_rd : b_rd;

  // Write data for the row being written.
  always_comb begin
    case (cmd.wd_sel)
      WD_J:     wdata = TRIALS_W'(j_r);
      WD_ZERO:  wdata = '0;
      WD_ONE:   wdata = TRIALS_W'(1);
      WD_PREV:  wdata = prev_rd;
      WD_BEST1: wdata = best_r + TRIALS_W'(1);
      default:  wdata = '0;
    endcase
  end

  assign a_we = cmd.wr_en && (cmd.wr_prev == !sel_r);
  assign b_we = cmd.wr_en && (cmd.wr_prev == sel_r);

  edmt_ram #(
    .WIDTH (TRIALS_W),
    .DEPTH (MAX_FLOORS + 1)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (j_r),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  edmt_ram #(
    .WIDTH (TRIALS_W),
    .DEPTH (MAX_FLOORS + 1)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (j_r),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  // Running minimum of the worse outcome over all drop floors.
  assign worst = (prev_rd > cur_rd) ? prev_rd : cur_rd;

  always_ff @(posedge clk) begin
    if (cmd.best_clr) begin
      best_r <= '1;
    end else if (rd_pend_r && (worst < best_r)) begin
      best_r <= worst;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        RES_ZERO: res_r <= '0;
        RES_ONE:  res_r <= TRIALS_W'(1);
        RES_K:    res_r <= TRIALS_W'(k_r);
        RES_MEM:  res_r <= prev_rd;
        default:  res_r <= '0;
      endcase
    end
  end
  assign out_trials = res_r;

  // Status back to the controller.
  always_comb begin
    stat.k_zero = (k_r == '0);
    stat.k_one  = (k_r == FW'(1));
    stat.n_zero = (n_r == '0);
    stat.n_one  = (n_r == EW'(1));
    stat.j_eq_k = (j_r == k_r);
    stat.x_eq_j = (x_r == j_r);
    stat.i_gt_j = (CMPW'(i_r) > CMPW'(j_r));
    stat.i_eq_n = (i_r == n_r);
  end

endmodule

// ===== rtl/egg_drop_min_trials_unit.sv =====
// The result comes straight from the size check when floors is 0 or 1 or eggs is 0 or 1.
// Otherwise the table is filled row by row for n eggs and k floors; the drop-floor scan reads
// one table entry pair per cycle from the two row RAMs, and a cell with more eggs than floors
// is copied from the previous row instead of scanned.
// Throughput: one transaction at a time; busy is high from accept until the strobe cycle ends.
// The result strobe lasts one cycle and cannot be stalled. Synchronous active-low reset
// returns the controller to idle; the row RAMs are not cleared.
module egg_drop_min_trials_unit #(
  parameter int MAX_FLOORS = 1023,
  parameter int MAX_EGGS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [edmt_pkg::EGGS_W-1:0]   in_eggs,
  input  logic [edmt_pkg::FLOORS_W-1:0] in_floors,
  output logic                          out_valid,
  output logic [edmt_pkg::TRIALS_W-1:0] out_trials
);

  import edmt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for the table fill.
  edmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Counters, row RAMs and the min/max unit.
  edmt_dp #(
    .MAX_FLOORS (MAX_FLOORS),
    .MAX_EGGS   (MAX_EGGS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_eggs    (in_eggs),
    .in_floors  (in_floors),
    .cmd        (cmd),
    .stat       (stat),
    .out_trials (out_trials)
  );

endmodule

// ===== rtl/edmt_checker.sv =====
module edmt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [edmt_pkg::EGGS_W-1:0]   in_eggs,
  input logic [edmt_pkg::FLOORS_W-1:0] in_floors,
  input logic                          out_valid,
  input logic [edmt_pkg::TRIALS_W-1:0] out_trials
);

  // An accepted transaction makes the unit busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The unit drops busy only right after delivering a result.
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("busy dropped without a result");

  // Zero floors answers zero on the short path, without a table fill.
  a_zero_floors: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_floors == '0)) |-> ##2 (out_valid && (out_trials == '0)))
    else $error("zero floors gave a wrong or late result");

  // With a single egg every floor must be tried, so the answer is the floor count.
  a_one_egg: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_eggs == edmt_pkg::EGGS_W'(1))) |->
      ##2 (out_valid && (out_trials == $past(in_floors, 2))))
    else $error("one egg gave a wrong or late result");

endmodule

bind egg_drop_min_trials_unit edmt_checker u_edmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_eggs    (in_eggs),
  .in_floors  (in_floors),
  .out_valid  (out_valid),
  .out_trials (out_trials)
);
